@@ design/tsm_pkg.sv @@
// Shared types and constants of the timestamp stream merger.
// Used by tsm_cell and timestamp_stream_merger_unit; no dependencies.
package tsm_pkg;

  localparam int MaxStreams = 64;
  localparam int IdxW       = (MaxStreams > 1) ? $clog2(MaxStreams) : 1;
  localparam int IdW        = 6;
  localparam int ClkW       = 64;
  localparam int DeltaW     = 63;
  localparam int CntW       = $clog2(MaxStreams + 1);
  localparam int InDataW    = 72;
  localparam int OutDataW   = 136;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_POP   = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_BACK  = 2'd2
  } status_e;

  // Write broadcast to all cells.
  typedef struct packed {
    logic            en;
    logic            set;
    logic [IdxW-1:0] idx;
    logic [ClkW-1:0] clk;
  } wr_cmd_t;

  // Running minimum handed from cell to cell.
  typedef struct packed {
    logic            vld;
    logic [IdxW-1:0] idx;
    logic [ClkW-1:0] clk;
  } best_t;

endpackage

@@ design/tsm_cell.sv @@
// One stream slot: head clock, pending flag and one stage of the minimum chain.
// Depends on tsm_pkg.
module tsm_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [tsm_pkg::IdxW-1:0] cell_idx_i,
  input  tsm_pkg::wr_cmd_t      wr_i,
  input  tsm_pkg::best_t        best_i,
  output tsm_pkg::best_t        best_o
);
  import tsm_pkg::*;

  logic            hit;
  logic            vld_q;
  logic [ClkW-1:0] clk_q;
  logic            mine;
  best_t           best_d;
  best_t           best_q;

  assign hit = wr_i.en && (wr_i.idx == cell_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (hit) begin
      vld_q <= wr_i.set;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit && wr_i.set) begin
      clk_q <= wr_i.clk;
    end
  end

  // ties go to the lower stream number
  assign mine = vld_q && (!best_i.vld || ($signed(clk_q) <= $signed(best_i.clk)));

  always_comb begin
    if (mine) begin
      best_d.vld = 1'b1;
      best_d.idx = cell_idx_i;
      best_d.clk = clk_q;
    end else begin
      best_d = best_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule

@@ design/timestamp_stream_merger_unit.sv @@
// Timestamp stream merger top level: stream ports, cell chain and step control.
// Depends on tsm_pkg and tsm_cell.
//
// Each stream owns one cell; cells pass a running minimum to their lower
// neighbor every cycle, so the smallest pending clock (lowest stream on ties)
// reaches cell 0 after rippling down the chain of cell registers. A load
// beat yields no output. A step beat yields one output beat once that ripple
// through the chain has settled; loads right before a step lengthen its
// wait the same way, and a previous result that is not yet taken holds the
// pop back further. The input stays not ready from a step beat until its
// pop. The output register lets loads go on while a result waits to be taken.
module timestamp_stream_merger_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [5:0] stream_id, [69:6] head_clock, [70] refill_valid, [71] zero
  input  logic [tsm_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] kind
  input  logic [0:0]                   s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [5:0] stream_id_out, [69:6] event_clock, [132:70] delta_clock, [135:133] zero
  output logic [tsm_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]                   m_axis_tuser_o
);
  import tsm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WAIT
  } state_e;

  state_e          state_q;
  logic            in_fire;
  logic            is_step;
  logic [IdW-1:0]  in_sid;
  logic [ClkW-1:0] in_clk;
  logic            in_refill;
  logic            sid_ok;
  logic            pop;

  logic [IdxW-1:0] cur_q;
  logic            cur_vld_q;
  logic            first_pend_q;
  logic [ClkW-1:0] first_q;
  logic [ClkW-1:0] last_q;
  logic [CntW-1:0] cnt_q;

  logic            m_vld_q;
  status_e         status_q;
  logic [IdW-1:0]  sid_out_q;
  logic [ClkW-1:0] evt_q;
  logic [DeltaW-1:0] delta_q;

  wr_cmd_t         wr;
  best_t           chain [MaxStreams+1];
  best_t           top;
  logic [ClkW-1:0] first_eff;
  logic [ClkW-1:0] last_eff;
  logic [ClkW-1:0] diff;
  logic            back;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_step   = (s_axis_tuser_i[0] == KIND_STEP);
  assign in_sid    = s_axis_tdata_i[IdW-1:0];
  assign in_clk    = s_axis_tdata_i[IdW+ClkW-1:IdW];
  assign in_refill = s_axis_tdata_i[IdW+ClkW];
  assign sid_ok    = (32'(in_sid) < MaxStreams);

  assign top = chain[0];
  assign pop = (state_q == ST_WAIT) && (cnt_q == CntW'(MaxStreams))
               && (!m_vld_q || m_axis_tready_i);

  always_comb begin
    wr = '0;
    if (in_fire && !is_step) begin
      wr.en  = sid_ok;
      wr.set = 1'b1;
      wr.idx = IdxW'(in_sid);
      wr.clk = in_clk;
    end else if (in_fire && is_step) begin
      wr.en  = cur_vld_q && in_refill;
      wr.set = 1'b1;
      wr.idx = cur_q;
      wr.clk = in_clk;
    end else if (pop) begin
      wr.en  = top.vld;
      wr.set = 1'b0;
      wr.idx = top.idx;
    end
  end

  assign chain[MaxStreams] = '0;

  for (genvar g = 0; g < MaxStreams; g++) begin : g_cell
    tsm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IdxW'(g)),
      .wr_i       (wr),
      .best_i     (chain[g+1]),
      .best_o     (chain[g])
    );
  end

  assign first_eff = first_pend_q ? top.clk : first_q;
  assign last_eff  = first_pend_q ? top.clk : last_q;
  assign back      = $signed(top.clk) < $signed(last_eff);
  assign diff      = top.clk - first_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_q        <= '0;
      cur_vld_q    <= 1'b0;
      first_pend_q <= 1'b1;
      first_q      <= '0;
      last_q       <= '0;
      cnt_q        <= CntW'(MaxStreams);
      m_vld_q      <= 1'b0;
      status_q     <= STATUS_POP;
      sid_out_q    <= '0;
      evt_q        <= '0;
      delta_q      <= '0;
    end else begin
      if (wr.en) begin
        cnt_q <= '0;
      end else if (cnt_q != CntW'(MaxStreams)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (pop) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && is_step) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (pop) begin
            state_q <= ST_IDLE;
            if (!top.vld) begin
              cur_vld_q <= 1'b0;
            end else begin
              if (first_pend_q) begin
                first_pend_q <= 1'b0;
                first_q      <= top.clk;
              end
              if (back) begin
                cur_vld_q <= 1'b0;
                last_q    <= last_eff;
              end else begin
                last_q    <= top.clk;
                cur_q     <= top.idx;
                cur_vld_q <= 1'b1;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (pop) begin
        if (!top.vld) begin
          status_q  <= STATUS_EMPTY;
          sid_out_q <= '0;
          evt_q     <= '0;
          delta_q   <= '0;
        end else if (back) begin
          status_q  <= STATUS_BACK;
          sid_out_q <= IdW'(top.idx);
          evt_q     <= top.clk;
          delta_q   <= '0;
        end else begin
          status_q  <= STATUS_POP;
          sid_out_q <= IdW'(top.idx);
          evt_q     <= top.clk;
          delta_q   <= diff[ClkW-1] ? '1 : diff[DeltaW-1:0];
        end
      end
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {(OutDataW-IdW-ClkW-DeltaW)'(0), delta_q, evt_q, sid_out_q};

endmodule

@@ bench/tb_timestamp_stream_merger_unit.sv @@
// Testbench for timestamp_stream_merger_unit: load and step beats, with directed tables
// and a random part, checked against a behavioral merge predictor or fixed rows.
// Depends on tsm_pkg and the design files.
`timescale 1ns / 100ps

module tb_timestamp_stream_merger_unit;
  import tsm_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandBeats  = 800;
  localparam logic signed [ClkW-1:0] ClkMin = 64'h8000_0000_0000_0000;
  localparam logic signed [ClkW-1:0] ClkMax = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    kind_e                   kind;
    logic [IdW-1:0]          id;
    logic signed [ClkW-1:0]  clk;
    logic                    refill;
  } in_beat_t;

  typedef struct {
    status_e                 status;
    logic [IdW-1:0]          id;
    logic [ClkW-1:0]         clk;
    logic [DeltaW-1:0]       delta;
  } merge_result_t;

  typedef struct {
    in_beat_t      beat;
    bit            typed;
    merge_result_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [InDataW-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tready = 1'b0;
  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;

  // merge state mirror
  logic signed [ClkW-1:0] queued_clk[MaxStreams];
  bit queued[MaxStreams];
  logic [IdW-1:0] last_id = '0;
  bit last_live = 1'b0;
  bit none_popped = 1'b1;
  logic signed [ClkW-1:0] origin_clk = '0;
  logic signed [ClkW-1:0] latest_clk = '0;

  merge_result_t due_events[$];
  stim_row_t rows[$];
  int err_cnt = 0;
  int beats_in = 0;
  int cycle_cnt = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  timestamp_stream_merger_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit merge_step(input in_beat_t b, output merge_result_t r);
    int best;
    bit found;
    logic signed [ClkW-1:0] best_clk;
    logic [ClkW-1:0] span;
    r.status = STATUS_EMPTY;
    r.id = '0;
    r.clk = '0;
    r.delta = '0;
    best = 0;
    found = 1'b0;
    best_clk = '0;
    if (b.kind == KIND_LOAD) begin
      queued_clk[b.id] = b.clk;
      queued[b.id] = 1'b1;
      return 1'b0;
    end
    if (last_live && b.refill) begin
      queued_clk[last_id] = b.clk;
      queued[last_id] = 1'b1;
    end
    for (int i = 0; i < MaxStreams; i++) begin
      if (queued[i] && (!found || queued_clk[i] < best_clk)) begin
        found = 1'b1;
        best = i;
        best_clk = queued_clk[i];
      end
    end
    if (!found) begin
      last_live = 1'b0;
      return 1'b1;
    end
    queued[best] = 1'b0;
    if (none_popped) begin
      none_popped = 1'b0;
      origin_clk = best_clk;
      latest_clk = best_clk;
    end
    r.id = IdW'(best);
    r.clk = best_clk;
    if (best_clk < latest_clk) begin
      last_live = 1'b0;
      r.status = STATUS_BACK;
      return 1'b1;
    end
    latest_clk = best_clk;
    last_id = IdW'(best);
    last_live = 1'b1;
    span = best_clk - origin_clk;
    r.status = STATUS_POP;
    r.delta = span[ClkW-1] ? '1 : span[DeltaW-1:0];
    return 1'b1;
  endfunction

  function automatic bit any_queued();
    foreach (queued[i]) if (queued[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void put_row(kind_e kind, logic [IdW-1:0] id,
                                  logic signed [ClkW-1:0] clk, logic refill,
                                  bit typed = 1'b0, status_e st = STATUS_POP,
                                  logic [IdW-1:0] rid = '0, logic [ClkW-1:0] rclk = '0,
                                  logic [DeltaW-1:0] rdelta = '0);
    stim_row_t row;
    row.beat.kind = kind;
    row.beat.id = id;
    row.beat.clk = clk;
    row.beat.refill = refill;
    row.typed = typed;
    row.want.status = st;
    row.want.id = rid;
    row.want.clk = rclk;
    row.want.delta = rdelta;
    rows.push_back(row);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(input in_beat_t b, input bit typed, input merge_result_t want);
    merge_result_t got;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, b.refill, b.clk, b.id};
    s_tuser <= b.kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    beats_in++;
    if (merge_step(b, got)) due_events.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  task automatic load_beat(input logic [IdW-1:0] id, input logic signed [ClkW-1:0] clk);
    in_beat_t b;
    merge_result_t none;
    b.kind = KIND_LOAD;
    b.id = id;
    b.clk = clk;
    b.refill = 1'($urandom);
    send_beat(b, 1'b0, none);
  endtask

  task automatic step_beat(input logic refill, input logic signed [ClkW-1:0] clk);
    in_beat_t b;
    merge_result_t none;
    b.kind = KIND_STEP;
    b.id = IdW'($urandom);
    b.clk = clk;
    b.refill = refill;
    send_beat(b, 1'b0, none);
  endtask

  task automatic run_rows();
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].want);
    rows.delete();
  endtask

  task automatic check_field(input string name, input logic [ClkW-1:0] want,
                             input logic [ClkW-1:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    merge_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (due_events.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat, expected none, actual status %0d data %h",
                 $time, m_axis_tuser_o, m_axis_tdata_o);
      end else begin
        want = due_events.pop_front();
        check_field("status", ClkW'(want.status), ClkW'(m_axis_tuser_o));
        check_field("stream_id_out", ClkW'(want.id), ClkW'(m_axis_tdata_o[5:0]));
        check_field("event_clock", want.clk, m_axis_tdata_o[69:6]);
        check_field("delta_clock", ClkW'(want.delta), ClkW'(m_axis_tdata_o[132:70]));
        check_field("pad", '0, ClkW'(m_axis_tdata_o[135:133]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_events.size());
      $display("tb: failure");
      $finish;
    end
  end

  // sink stalls
  initial begin
    repeat (5) @(negedge clk_i);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int pick;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed head; latest_clk stays negative so the random part keeps popping
    put_row(KIND_STEP, 6'd0, 64'h1234, 1'b1, 1'b1, STATUS_EMPTY);
    put_row(KIND_LOAD, 6'd63, ClkMin + 1000, 1'b0);
    put_row(KIND_LOAD, 6'd0, ClkMin, 1'b1);
    put_row(KIND_LOAD, 6'd5, ClkMin + 500, 1'b0);
    put_row(KIND_LOAD, 6'd5, ClkMin + 200, 1'b0);
    put_row(KIND_STEP, 6'd63, '1, 1'b0, 1'b1, STATUS_POP, 6'd0, ClkMin, '0);
    put_row(KIND_LOAD, 6'd1, ClkMin + 300, 1'b0);
    put_row(KIND_LOAD, 6'd2, ClkMin + 300, 1'b0);
    put_row(KIND_STEP, 6'd0, ClkMin + 300, 1'b1);
    put_row(KIND_STEP, 6'd0, '0, 1'b0);
    put_row(KIND_LOAD, 6'd0, ClkMin + 7, 1'b0);
    put_row(KIND_STEP, 6'd0, ClkMin + 250, 1'b1);
    put_row(KIND_STEP, 6'd0, 64'd3, 1'b1);
    put_row(KIND_STEP, 6'd0, '0, 1'b0);
    put_row(KIND_STEP, 6'd0, ClkMin + 10, 1'b1);
    put_row(KIND_STEP, 6'd0, '0, 1'b0);
    put_row(KIND_STEP, 6'd0, '0, 1'b0, 1'b1, STATUS_EMPTY);
    put_row(KIND_STEP, 6'd0, 64'd5, 1'b1, 1'b1, STATUS_EMPTY);
    put_row(KIND_LOAD, 6'd21, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    put_row(KIND_STEP, 6'd42, '0, 1'b0);
    run_rows();

    beats_in = 0;
    while (beats_in < RandBeats) begin
      calm = (beats_in > RandBeats - 100);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        repeat ($urandom_range(1, 8))
          load_beat(IdW'($urandom), latest_clk + ClkW'($urandom_range(0, 65535)));
        repeat ($urandom_range(1, 12))
          step_beat($urandom_range(0, 3) != 0, latest_clk + ClkW'($urandom_range(0, 4096)));
      end else if (pick == 7) begin
        if ($urandom_range(0, 1) == 0) begin
          step_beat(1'b1, latest_clk - ClkW'($urandom_range(1, 4096)));
        end else begin
          load_beat(IdW'($urandom), latest_clk - ClkW'($urandom_range(1, 4096)));
          step_beat(1'b0, '0);
        end
      end else if (pick == 8) begin
        while (any_queued()) step_beat(1'b0, ClkW'($urandom));
        repeat ($urandom_range(1, 3)) step_beat(1'($urandom), ClkW'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          load_beat(IdW'($urandom), latest_clk + ClkW'({$urandom_range(0, 255), $urandom}));
        step_beat(1'b1, latest_clk + ClkW'({$urandom_range(0, 255), $urandom}));
      end
    end

    // tail: positive clocks, saturated delta, ties at the top of the range
    while (any_queued()) step_beat(1'b0, '0);
    put_row(KIND_LOAD, 6'd42, 64'h5555_5555_5555_5555, 1'b0);
    put_row(KIND_LOAD, 6'd63, ClkMax, 1'b0);
    put_row(KIND_STEP, 6'd0, '0, 1'b0);
    put_row(KIND_STEP, 6'd0, ClkMax, 1'b1);
    put_row(KIND_STEP, 6'd0, '0, 1'b0);
    put_row(KIND_STEP, 6'd0, '0, 1'b0, 1'b1, STATUS_EMPTY);
    run_rows();
    s_tvalid <= 1'b0;

    while (due_events.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/tsm_pkg.sv
design/tsm_cell.sv
design/timestamp_stream_merger_unit.sv
bench/tb_timestamp_stream_merger_unit.sv
